// File: sv/mmgp_pkg.sv
package mmgp_pkg;
   localparam int MAX_POINTS = 1024;
   localparam int POS_W      = 32;
   localparam int CNT_W      = 11;
   localparam logic [CNT_W-1:0] COUNT_RESET = 11'd2;
endpackage

// File: sv/mmgp_if.sv
interface mmgp_req_if;
   logic                         valid;
   logic                         ready;
   logic [mmgp_pkg::POS_W-1:0]   position;
   logic                         last_point;
   modport source (output valid, position, last_point, input ready);
   modport sink   (input valid, position, last_point, output ready);
endinterface

interface mmgp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mmgp_pkg::POS_W-1:0]   max_min_gap;
   logic                         overflow;
   modport source (output valid, max_min_gap, overflow, input ready);
   modport sink   (input valid, max_min_gap, overflow, output ready);
endinterface

interface mmgp_csr_if;
   logic                         valid;
   logic                         ready;
   logic [mmgp_pkg::CNT_W-1:0]   data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: sv/mmgp_ram.sv
module mmgp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: sv/max_min_gap_placement.sv
// points load one word at a time: the first of a set is written at once, each later one takes
// a read and a compare, plus one more read and compare for every stored entry larger than it
// insertion sort: each point shifts larger entries up one at a time through the single RAM
// search: up to 32 trials, each a greedy scan of the stored points with one subtract/compare
// one set in flight, not ready for new points until the result is taken
// reset (synchronous, active high) clears counts, flags and sets the required pick count to 2
module max_min_gap_placement #(
   parameter int MAX_POINTS = mmgp_pkg::MAX_POINTS
) (
   input  logic        clock,
   input  logic        reset,
   mmgp_req_if.sink    req,
   mmgp_rsp_if.source  rsp,
   mmgp_csr_if.sink    csr
);
   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int PW = mmgp_pkg::POS_W;

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_SRD   = 4'd1;
   localparam logic [3:0] S_SCMP  = 4'd2;
   localparam logic [3:0] S_SPAN0 = 4'd3;
   localparam logic [3:0] S_SPAN1 = 4'd4;
   localparam logic [3:0] S_SPAN2 = 4'd5;
   localparam logic [3:0] S_TINIT = 4'd6;
   localparam logic [3:0] S_TRD   = 4'd7;
   localparam logic [3:0] S_TCMP  = 4'd8;
   localparam logic [3:0] S_TEND  = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   logic [3:0]     state_ff, state_in;
   logic [NW-1:0]  count_ff, count_in;
   logic [NW-1:0]  idx_ff, idx_in;
   logic           ovf_ff, ovf_in;
   logic [mmgp_pkg::CNT_W-1:0] need_ff;
   logic [PW-1:0]  val_ff, val_in;       // point being inserted
   logic [PW-1:0]  first_ff, first_in;
   logic [PW:0]    lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [PW-1:0]  best_ff, best_in;
   logic [PW-1:0]  lastp_ff, lastp_in;
   logic [NW:0]    picks_ff, picks_in;
   logic [PW-1:0]  res_ff, res_in;
   logic           rov_ff, rov_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [PW-1:0] wr_data, rd_data;
   logic [PW-1:0] diff;
   logic [PW:0]   mid_calc;

   mmgp_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_store (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   assign req.ready     = (state_ff == S_LOAD);
   assign csr.ready     = 1'b1;
   assign rsp.valid     = (state_ff == S_OUT);
   assign rsp.max_min_gap = res_ff;
   assign rsp.overflow  = rov_ff;
   assign diff          = rd_data - lastp_ff;
   assign mid_calc      = lo_ff + ((hi_ff - lo_ff) >> 1);

   // config register
   always_ff @(posedge clock) begin
      if (reset) need_ff <= mmgp_pkg::COUNT_RESET;
      else if (csr.valid) need_ff <= csr.data;
   end

   // sequencer
   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; ovf_in = ovf_ff;
      val_in = val_ff; first_in = first_ff; lo_in = lo_ff; hi_in = hi_ff;
      mid_in = mid_ff; best_in = best_ff; lastp_in = lastp_ff; picks_in = picks_ff;
      res_in = res_ff; rov_in = rov_ff;
      wr_en = 1'b0; wr_addr = idx_ff[AW-1:0]; wr_data = val_ff;
      rd_addr = idx_ff[AW-1:0];
      unique case (state_ff)
         S_LOAD: begin
            if (req.valid) begin
               if (count_ff == NW'(MAX_POINTS)) begin
                  ovf_in = 1'b1;
                  if (req.last_point) state_in = S_SPAN0;
               end else begin
                  val_in = req.position;
                  idx_in = count_ff;
                  state_in = S_SRD;
               end
               rov_in = req.last_point;
            end
         end
         S_SRD: begin
            // read entry below the hole
            if (idx_ff == '0) begin
               wr_en = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = rov_ff ? S_SPAN0 : S_LOAD;
            end else begin
               rd_addr = AW'(idx_ff - 1'b1);
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            if (rd_data > val_ff) begin
               wr_en = 1'b1; wr_data = rd_data;
               idx_in = idx_ff - 1'b1;
               state_in = S_SRD;
            end else begin
               wr_en = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = rov_ff ? S_SPAN0 : S_LOAD;
            end
         end
         S_SPAN0: begin
            rov_in = ovf_ff;
            rd_addr = '0;
            state_in = S_SPAN1;
         end
         S_SPAN1: begin
            first_in = rd_data;
            rd_addr = AW'(count_ff - 1'b1);
            state_in = S_SPAN2;
         end
         S_SPAN2: begin
            lo_in = (PW+1)'(1);
            hi_in = {1'b0, rd_data - first_ff};
            best_in = '0;
            state_in = S_TINIT;
         end
         S_TINIT: begin
            if (lo_ff > hi_ff) begin
               res_in = best_ff;
               state_in = S_OUT;
            end else begin
               mid_in = mid_calc;
               picks_in = (NW+1)'(1);
               lastp_in = first_ff;
               idx_in = NW'(1);
               state_in = S_TRD;
            end
         end
         S_TRD: begin
            if (idx_ff >= count_ff) state_in = S_TEND;
            else state_in = S_TCMP;
         end
         S_TCMP: begin
            // greedy pick
            if ({1'b0, diff} >= mid_ff) begin
               picks_in = picks_ff + 1'b1;
               lastp_in = rd_data;
            end
            idx_in = idx_ff + 1'b1;
            state_in = S_TRD;
         end
         S_TEND: begin
            if (picks_ff >= (NW+1)'(need_ff)) begin
               best_in = mid_ff[PW-1:0];
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff - 1'b1;
            end
            state_in = S_TINIT;
         end
         S_OUT: begin
            if (rsp.ready) begin
               count_in = '0; ovf_in = 1'b0;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; count_ff <= '0; ovf_ff <= 1'b0; rov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; ovf_ff <= ovf_in; rov_ff <= rov_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in; val_ff <= val_in; first_ff <= first_in;
      lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in; best_ff <= best_in;
      lastp_ff <= lastp_in; picks_ff <= picks_in; res_ff <= res_in;
   end
endmodule

// File: test/tb_mmgp_sb.sv
`timescale 1ns / 100ps

// tracks the loaded set and the expected gap results
class gap_scoreboard;
   bit [31:0]  set_points[$];
   bit         set_overflow;
   bit [10:0]  pick_count;
   bit [31:0]  exp_gap[$];
   bit         exp_ovf[$];
   int         errors;

   function new();
      set_overflow = 0;
      pick_count   = mmgp_pkg::COUNT_RESET;
      errors       = 0;
   endfunction

   // greedy pick check for one trial gap
   function bit gap_fits(bit [31:0] gap);
      int        picks;
      bit [31:0] prev;
      picks = 1;
      prev  = set_points[0];
      for (int i = 1; i < set_points.size(); i++) begin
         if (set_points[i] - prev >= gap) begin
            picks++;
            prev = set_points[i];
         end
      end
      return picks >= pick_count;
   endfunction

   // binary search over the span
   function bit [31:0] best_gap();
      longint lo, hi, mid;
      bit [31:0] best;
      best = 0;
      if (set_points.size() == 0) return 0;
      lo = 1;
      hi = set_points[set_points.size()-1] - set_points[0];
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (gap_fits(mid[31:0])) begin
            best = mid[31:0];
            lo = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      return best;
   endfunction

   // note an accepted point word
   function void note_point(bit [31:0] pos, bit last);
      if (set_points.size() < mmgp_pkg::MAX_POINTS) begin
         set_points.push_back(pos);
         set_points.sort();
      end else begin
         set_overflow = 1;
      end
      if (last) begin
         exp_gap.push_back(best_gap());
         exp_ovf.push_back(set_overflow);
         set_points.delete();
         set_overflow = 0;
      end
   endfunction

   function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endfunction

   // check one result word
   function void check_result(bit [31:0] gap, bit ovf);
      bit [31:0] eg;
      bit        eo;
      if (exp_gap.size() == 0) begin
         report($sformatf("unexpected result gap=%0d", gap));
         return;
      end
      eg = exp_gap.pop_front();
      eo = exp_ovf.pop_front();
      if (gap !== eg) report($sformatf("gap %0d, wanted %0d", gap, eg));
      if (ovf !== eo) report($sformatf("overflow %0b, wanted %0b", ovf, eo));
   endfunction
endclass

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   bit   hold_off;

   mmgp_req_if req ();
   mmgp_rsp_if rsp ();
   mmgp_csr_if csr ();

   gap_scoreboard sb;

   max_min_gap_placement u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("TEST FAILED");
      $finish;
   end

   // result side: random stall, check each accepted word
   initial begin
      rsp.ready = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready)
            sb.check_result(rsp.max_min_gap, rsp.overflow);
         rsp.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // send one point word; valid stays up until the next idle or drain
   task automatic send_point(bit [31:0] pos, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid      <= 1;
      req.position   <= pos;
      req.last_point <= last;
      do @(posedge clock); while (!req.ready);
      sb.note_point(pos, last);
   endtask

   // write the pick count while idle
   task automatic write_count(bit [10:0] val);
      csr.valid <= 1;
      csr.data  <= val;
      do @(posedge clock); while (!csr.ready);
      sb.pick_count = val;
      csr.valid <= 0;
   endtask

   task automatic drain();
      int n;
      req.valid <= 0;
      n = 0;
      while (sb.exp_gap.size() != 0 && n < 20000000) begin
         @(posedge clock);
         n++;
      end
      repeat (20) @(posedge clock);
   endtask

   // one random set, mostly small
   task automatic send_set(int npts, bit wide);
      bit [31:0] pos;
      for (int i = 0; i < npts; i++) begin
         pos = wide ? $urandom() : $urandom_range(200);
         if ($urandom_range(9) == 0 && i > 0) pos = sb.set_points[0];
         send_point(pos, i == npts - 1);
      end
   endtask

   initial begin
      sb = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off       = 0;
      req.valid = 0; req.position = 0; req.last_point = 0;
      csr.valid = 0; csr.data = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: default count, extremes, single point, duplicates
      send_point(32'h0, 0);
      send_point(32'hFFFF_FFFF, 1);
      send_point(32'd77, 1);
      send_point(32'd5, 0); send_point(32'd5, 0); send_point(32'd5, 1);
      drain();
      write_count(11'd3);
      send_point(32'd9, 0); send_point(32'd1, 0); send_point(32'd4, 0);
      send_point(32'd8, 0); send_point(32'd2, 1);
      drain();
      write_count(11'd7);                 // count above the set size
      send_point(32'd10, 0); send_point(32'd20, 1);
      drain();
      write_count(11'd0);                 // every trial passes
      send_point(32'hAAAA_5555, 0); send_point(32'h5555_AAAA, 1);
      drain();
      write_count(11'd2047);
      send_point(32'd3, 0); send_point(32'd1000, 1);
      drain();
      write_count(11'd1);
      send_point(32'd3, 0); send_point(32'd1000, 1);
      drain();

      // overflow set: MAX_POINTS + 2 words, dropped last closes it
      write_count(11'd1024);
      for (int i = 0; i < mmgp_pkg::MAX_POINTS + 2; i++)
         send_point(i * 3, i == mmgp_pkg::MAX_POINTS + 1);
      drain();

      // random phases of idling
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 45 : (ph == 3) ? 16 : 0;
         recv_stall_pct = (ph == 2) ? 45 : (ph == 3) ? 16 : 0;
         write_count($urandom_range(5) == 0 ? 11'd1024 : 11'($urandom_range(1, 6)));
         for (int s = 0; s < 14; s++) begin
            send_set($urandom_range(1, 12), $urandom_range(1));
         end
         drain();
      end

      // long hold-off on results while points keep coming
      fork
         begin
            hold_off = 1;
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         begin
            for (int s = 0; s < 6; s++) send_set($urandom_range(2, 8), 1);
            req.valid <= 0;
            @(posedge clock);
         end
      join
      drain();
      write_count(11'($urandom_range(2, 4)));
      send_set(200, 1);
      drain();

      if (sb.errors == 0 && sb.exp_gap.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// File: max_min_gap_placement.f
sv/mmgp_pkg.sv
sv/mmgp_if.sv
sv/mmgp_ram.sv
sv/max_min_gap_placement.sv
test/tb_mmgp_sb.sv
test/tb_top.sv
